// File: sv/fwdf_pkg.sv
// Shared types, constants and helpers for the fixed-width decimal formatter.
// Used by fwdf_front, fwdf_queue, fwdf_back and the top level.
`timescale 1ns / 1ps
package fwdf_pkg;

    localparam int MAX_BUFFER    = 32;
    localparam int MAX_PRECISION = 9;

    localparam logic [10:0] EXP_SPECIAL = 11'h7FF;
    localparam logic [10:0] EXP_SHIFT0  = 11'd1075;  // exponent with no fraction bits
    localparam logic [10:0] EXP_TINY    = 11'd971;   // below this the value rounds to zero
    localparam logic [31:0] SAT_INT     = 32'hFFFF_FFFF;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [1:0] {
        KIND_NUM,
        KIND_NAN,
        KIND_INF,
        KIND_TINY
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        neg;
        logic [4:0]  room;
        logic [4:0]  pad;
        logic [3:0]  prec;
        logic [10:0] expo;
        logic [51:0] mant;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_SCALE,
        ST_ROUND,
        ST_CARRY,
        ST_BCD,
        ST_LAYOUT,
        ST_EMIT
    } back_state_t;

    function automatic logic [33:0] pow10(input logic [3:0] p);
        logic [33:0] r;
        unique case (p)
            4'd0:    r = 34'd1;
            4'd1:    r = 34'd10;
            4'd2:    r = 34'd100;
            4'd3:    r = 34'd1000;
            4'd4:    r = 34'd10000;
            4'd5:    r = 34'd100000;
            4'd6:    r = 34'd1000000;
            4'd7:    r = 34'd10000000;
            4'd8:    r = 34'd100000000;
            default: r = 34'd1000000000;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] special_char(input kind_t k, input logic [4:0] i);
        logic [7:0] c;
        if (k == KIND_NAN)
            c = (i == 5'd1) ? 8'h61 : 8'h6E;   // n a n
        else
            c = (i == 5'd0) ? 8'h69 : ((i == 5'd1) ? 8'h6E : 8'h66);  // i n f
        return c;
    endfunction

endpackage

// File: sv/fwdf_front.sv
// Front end: classifies an incoming request and clamps its size fields.
// Depends on fwdf_pkg.
`timescale 1ns / 1ps
module fwdf_front (
    input  logic [63:0]         value_bits,
    input  logic [5:0]          buffer_size,
    input  logic [4:0]          field_width,
    input  logic [3:0]          precision,
    output fwdf_pkg::item_t     item
);
    import fwdf_pkg::*;

    logic [5:0]  size_c;
    logic [4:0]  room;
    logic [10:0] expo;
    logic [51:0] mant;

    always_comb
    begin
        size_c = (buffer_size > 6'(MAX_BUFFER)) ? 6'(MAX_BUFFER) : buffer_size;
        room   = 5'(size_c - 6'd1);
        expo   = value_bits[62:52];
        mant   = value_bits[51:0];

        item.expo = expo;
        item.mant = mant;
        item.room = room;
        item.pad  = (field_width < room) ? field_width : room;
        item.prec = (precision > 4'(MAX_PRECISION)) ? 4'(MAX_PRECISION) : precision;
        item.neg  = 1'b0;
        priority if (size_c < 6'd2)
            item.kind = KIND_TINY;
        else if (expo == EXP_SPECIAL)
            item.kind = (mant != 52'd0) ? KIND_NAN : KIND_INF;
        else
        begin
            item.kind = KIND_NUM;
            // negative zero gets no sign
            item.neg  = value_bits[63] && (value_bits[62:0] != 63'd0);
        end
    end

endmodule

// File: sv/fwdf_queue.sv
// Two-entry request queue between the front and back ends.
// Depends on fwdf_pkg.
`timescale 1ns / 1ps
module fwdf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  fwdf_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output fwdf_pkg::item_t pop_item
);
    import fwdf_pkg::*;

    item_t      mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_next    = do_push ? ~wr_reg : wr_reg;
        rd_next    = do_pop ? ~rd_reg : rd_reg;
        count_next = 2'(count_reg + {1'b0, do_push} - {1'b0, do_pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule

// File: sv/fwdf_back.sv
// Back end: exact rounding, binary to BCD conversion, layout and character output.
// Depends on fwdf_pkg.
`timescale 1ns / 1ps
module fwdf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  fwdf_pkg::item_t item_in,
    output logic            valid,
    input  logic            ready,
    output logic [7:0]      character,
    output logic [4:0]      position,
    output logic            last,
    output logic [4:0]      length,
    output logic            no_store
);
    import fwdf_pkg::*;

    back_state_t  state_reg, state_next;
    item_t        item_reg, item_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [6:0]   s_reg, s_next;
    logic [83:0]  acc_reg, acc_next;
    logic [32:0]  whole_reg, whole_next;
    logic [33:0]  r_reg, r_next;
    logic [39:0]  bcdi_reg, bcdi_next;
    logic [35:0]  bcdf_reg, bcdf_next;
    logic [3:0]   nd_reg, nd_next;
    logic [4:0]   padn_reg, padn_next;
    logic [4:0]   len_reg, len_next;
    logic [4:0]   pos_reg, pos_next;
    logic         ov_reg, ov_next;
    logic [7:0]   ch_reg, ch_next;
    logic [4:0]   opos_reg, opos_next;
    logic         olast_reg, olast_next;
    logic [4:0]   olen_reg, olen_next;
    logic         ons_reg, ons_next;

    logic [52:0]  mag, mask53;
    logic [104:0] ext, shifted;
    logic [6:0]   sm1;
    logic [33:0]  scale;
    logic [39:0]  ai;
    logic [35:0]  af;
    logic [4:0]   roomA, rest, rem, used, j, j2, j3;
    logic         dot;
    logic [3:0]   fc, idx, fidx;
    logic [7:0]   ch;
    logic         emit_go;

    assign item_ready = (state_reg == ST_IDLE);
    assign valid      = ov_reg;
    assign character  = ch_reg;
    assign position   = opos_reg;
    assign last       = olast_reg;
    assign length     = olen_reg;
    assign no_store   = ons_reg;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        cnt_next   = cnt_reg;
        s_next     = s_reg;
        acc_next   = acc_reg;
        whole_next = whole_reg;
        r_next     = r_reg;
        bcdi_next  = bcdi_reg;
        bcdf_next  = bcdf_reg;
        nd_next    = nd_reg;
        padn_next  = padn_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        ch_next    = ch_reg;
        opos_next  = opos_reg;
        olast_next = olast_reg;
        olen_next  = olen_reg;
        ons_next   = ons_reg;
        ov_next    = ov_reg && !ready;

        scale   = pow10(item_reg.prec);
        mag     = {item_reg.expo != 11'd0, item_reg.mant};
        mask53  = ~({53{1'b1}} << s_reg);
        ext     = {21'd0, acc_reg};
        shifted = ext >> s_reg;
        sm1     = 7'(s_reg - 7'd1);
        ai      = '0;
        af      = '0;
        roomA = '0; rest = '0; rem = '0; used = '0; dot = 1'b0; fc = '0;
        j = '0; j2 = '0; j3 = '0; idx = '0; fidx = '0; ch = CH_NUL;
        emit_go = !ov_reg || ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item_in;
                    s_next     = 7'(EXP_SHIFT0 - item_in.expo);
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                cnt_next  = 6'd32;
                bcdi_next = '0;
                bcdf_next = '0;
                priority if (item_reg.kind != KIND_NUM)
                    state_next = ST_LAYOUT;
                else if (mag == 53'd0 || item_reg.expo < EXP_TINY)
                begin
                    whole_next = '0;
                    r_next     = '0;
                    state_next = ST_BCD;
                end
                else if (item_reg.expo >= EXP_SHIFT0 || (mag >> s_reg) > 53'(SAT_INT))
                begin
                    whole_next = {1'b0, SAT_INT};
                    r_next     = scale - 34'd1;
                    state_next = ST_BCD;
                end
                else
                begin
                    whole_next = 33'(mag >> s_reg);
                    acc_next   = 84'(mag & mask53);
                    cnt_next   = 6'(item_reg.prec);
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (cnt_reg == 6'd0)
                    state_next = ST_ROUND;
                else
                begin
                    acc_next = (acc_reg << 3) + (acc_reg << 1);
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            ST_ROUND:
            begin
                // half-up: floor of the shifted value plus the first dropped bit
                r_next     = shifted[33:0] + {33'd0, ext[sm1]};
                state_next = ST_CARRY;
            end
            ST_CARRY:
            begin
                if (r_reg >= scale)
                begin
                    if (whole_reg[31:0] == SAT_INT)
                        r_next = scale - 34'd1;
                    else
                    begin
                        r_next     = r_reg - scale;
                        whole_next = whole_reg + 33'd1;
                    end
                end
                cnt_next   = 6'd32;
                state_next = ST_BCD;
            end
            ST_BCD:
            begin
                if (cnt_reg == 6'd0)
                    state_next = ST_LAYOUT;
                else
                begin
                    for (int k = 0; k < 10; k++)
                        ai[4*k +: 4] = (bcdi_reg[4*k +: 4] >= 4'd5) ?
                                       4'(bcdi_reg[4*k +: 4] + 4'd3) : bcdi_reg[4*k +: 4];
                    for (int k = 0; k < 9; k++)
                        af[4*k +: 4] = (bcdf_reg[4*k +: 4] >= 4'd5) ?
                                       4'(bcdf_reg[4*k +: 4] + 4'd3) : bcdf_reg[4*k +: 4];
                    bcdi_next  = {ai[38:0], whole_reg[31]};
                    bcdf_next  = {af[34:0], r_reg[31]};
                    whole_next = {whole_reg[32], whole_reg[30:0], 1'b0};
                    r_next     = {r_reg[33:32], r_reg[30:0], 1'b0};
                    cnt_next   = cnt_reg - 6'd1;
                end
            end
            ST_LAYOUT:
            begin
                nd_next = 4'd1;
                for (int k = 1; k < 10; k++)
                    if (bcdi_reg[4*k +: 4] != 4'd0)
                        nd_next = 4'(k + 1);
                roomA = 5'(item_reg.room - {4'd0, item_reg.neg});
                padn_next = '0;
                unique case (item_reg.kind)
                    KIND_TINY: len_next = '0;
                    KIND_NAN, KIND_INF:
                        len_next = (item_reg.room < 5'd3) ? item_reg.room : 5'd3;
                    default:
                    begin
                        if ({1'b0, nd_next} > roomA)
                            len_next = {4'd0, item_reg.neg};   // sign only
                        else
                        begin
                            rest = roomA - {1'b0, nd_next};
                            dot  = (item_reg.prec != 4'd0) && (rest != 5'd0);
                            rem  = rest - {4'd0, dot};
                            fc   = ({1'b0, item_reg.prec} < rem) ? item_reg.prec : rem[3:0];
                            used = 5'({4'd0, item_reg.neg} + {1'b0, nd_next}
                                      + {4'd0, dot} + {1'b0, fc});
                            padn_next = (item_reg.pad > used) ? 5'(item_reg.pad - used) : 5'd0;
                            len_next  = 5'(used + padn_next);
                        end
                    end
                endcase
                pos_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    j  = pos_reg - padn_reg;
                    j2 = j - {4'd0, item_reg.neg};
                    j3 = j2 - {1'b0, nd_reg};
                    idx  = 4'(nd_reg - 4'd1 - j2[3:0]);
                    fidx = 4'(item_reg.prec - j3[3:0]);
                    unique case (item_reg.kind)
                        KIND_NAN, KIND_INF: ch = special_char(item_reg.kind, pos_reg);
                        KIND_TINY:          ch = CH_NUL;
                        default:
                        begin
                            priority if (pos_reg < padn_reg)
                                ch = CH_SPACE;
                            else if (item_reg.neg && j == 5'd0)
                                ch = CH_MINUS;
                            else if (j2 < {1'b0, nd_reg})
                                ch = CH_ZERO | {4'd0, bcdi_reg[{idx, 2'b00} +: 4]};
                            else if (j3 == 5'd0)
                                ch = CH_DOT;
                            else
                                ch = CH_ZERO | {4'd0, bcdf_reg[{fidx, 2'b00} +: 4]};
                        end
                    endcase
                    ov_next    = 1'b1;
                    opos_next  = pos_reg;
                    ons_next   = (item_reg.kind == KIND_TINY);
                    if (pos_reg == len_reg)
                    begin
                        ch_next    = CH_NUL;
                        olast_next = 1'b1;
                        olen_next  = len_reg;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch;
                        olast_next = 1'b0;
                        olen_next  = '0;
                        pos_next   = pos_reg + 5'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        cnt_reg   <= cnt_next;
        s_reg     <= s_next;
        acc_reg   <= acc_next;
        whole_reg <= whole_next;
        r_reg     <= r_next;
        bcdi_reg  <= bcdi_next;
        bcdf_reg  <= bcdf_next;
        nd_reg    <= nd_next;
        padn_reg  <= padn_next;
        len_reg   <= len_next;
        pos_reg   <= pos_next;
        ch_reg    <= ch_next;
        opos_reg  <= opos_next;
        olast_reg <= olast_next;
        olen_reg  <= olen_next;
        ons_reg   <= ons_next;
    end

    a_last_len: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |-> position == length && character == CH_NUL)
        else $error("terminator position differs from length");

    a_nostore_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && no_store |-> last && position == 5'd0)
        else $error("no_store on a non-final result");

    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable({character, position, last, length, no_store}))
        else $error("result changed while stalled");

endmodule

// File: sv/fixed_width_decimal_formatter.sv
// Fixed-width decimal formatter, top level.
// Depends on fwdf_pkg, fwdf_front, fwdf_queue, fwdf_back.
//
// A request on the input channel carries a double's raw bits, a buffer size,
// a field width and a precision. The block answers with one result per stored
// character on the output channel, in position order, the last one carrying
// the NUL terminator with last and length set. A buffer of 0 or 1 gives a
// single result with no_store set.
// The front end classifies each request and queues it (two entries); the back
// end handles one request at a time. For a finite nonzero value the first
// character follows precision multiply-by-ten steps, a rounding and a carry
// step, and a 32-step binary to BCD conversion. Zero, tiny and saturated
// values skip the scaling; nan, inf and a buffer of 0 or 1 skip the conversion
// too. Then one character per cycle while the receiver is ready.
// Reset clears the queue and the output register; no result is pending.
// When the receiver stalls, the output holds, the back end waits, and the
// queue takes up to two more requests before ready drops.
`timescale 1ns / 1ps
module fixed_width_decimal_formatter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value_bits,
    input  logic [5:0]  buffer_size,
    input  logic [4:0]  field_width,
    input  logic [3:0]  precision,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  character,
    output logic [4:0]  position,
    output logic        last,
    output logic [4:0]  length,
    output logic        no_store
);
    import fwdf_pkg::*;

    item_t front_item;
    item_t q_item;
    logic  q_valid;
    logic  q_ready;

    fwdf_front u_front (
        .value_bits  (value_bits),
        .buffer_size (buffer_size),
        .field_width (field_width),
        .precision   (precision),
        .item        (front_item)
    );

    fwdf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    fwdf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item_in    (q_item),
        .valid      (out_valid),
        .ready      (out_ready),
        .character  (character),
        .position   (position),
        .last       (last),
        .length     (length),
        .no_store   (no_store)
    );

endmodule

// File: verif/fwdf_checker.sv
// Checker for the fixed-width decimal formatter: watches both channels,
// predicts the character stream of each request and compares it.
// Depends on fwdf_pkg for the buffer and precision limits and character codes.
`timescale 1ns / 1ps
module fwdf_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] value_bits,
    input  logic [5:0]  buffer_size,
    input  logic [4:0]  field_width,
    input  logic [3:0]  precision,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  character,
    input  logic [4:0]  position,
    input  logic        last,
    input  logic [4:0]  length,
    input  logic        no_store,
    output int          fails,
    output int          pending,
    output int          chars_seen
);
    import fwdf_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic [4:0] pos;
        logic       last;
        logic [4:0] len;
        logic       no_store;
    } text_char_t;

    text_char_t expected_chars[$];

    initial begin
        fails = 0;
        pending = 0;
        chars_seen = 0;
    end

    function automatic logic [63:0] ten_to(input int p);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < p; i++) r = r * 64'd10;
        return r;
    endfunction

    // Exact half-up rounding of |value| at p fraction digits.
    task automatic split_rounded(input logic [63:0] bits, input int p,
                                 output logic [63:0] ipart, output logic [63:0] fdig);
        logic [63:0]  scale, whole, frac;
        logic [52:0]  mag;
        logic [127:0] prod;
        logic [10:0]  ex;
        int           e, s;
        scale = ten_to(p);
        ex = bits[62:52];
        if (ex == 11'd0) begin
            mag = {1'b0, bits[51:0]};
            e = -1074;
        end
        else begin
            mag = {1'b1, bits[51:0]};
            e = int'(ex) - 1075;
        end
        ipart = 64'd0;
        fdig = 64'd0;
        if (mag == 53'd0) return;
        if (e >= 0) begin
            ipart = 64'(SAT_INT);
            fdig = scale - 1;
            return;
        end
        s = -e;
        if (s > 104) return;
        if (s < 64) begin
            whole = 64'(mag) >> s;
            frac = 64'(mag) & ((64'd1 << s) - 1);
        end
        else begin
            whole = 64'd0;
            frac = 64'(mag);
        end
        if (whole > 64'(SAT_INT)) begin
            ipart = 64'(SAT_INT);
            fdig = scale - 1;
            return;
        end
        prod = 128'(frac) * 128'(scale);
        prod = prod + (128'd1 << (s - 1));
        fdig = 64'(prod >> s);
        if (fdig >= scale) begin
            fdig = fdig - scale;
            whole = whole + 1;
        end
        if (whole > 64'(SAT_INT)) begin
            ipart = 64'(SAT_INT);
            fdig = scale - 1;
            return;
        end
        ipart = whole;
    endtask

    task automatic predict_text(input logic [63:0] bits, input logic [5:0] size_in,
                                input logic [4:0] width_in, input logic [3:0] prec_in);
        logic [7:0]  text[0:MAX_BUFFER-1];
        logic [63:0] ipart, fdig, t;
        text_char_t  c;
        int          size, p, room, pad, len, nd;
        bit          skip;
        size = (int'(size_in) > MAX_BUFFER) ? MAX_BUFFER : int'(size_in);
        p = (int'(prec_in) > MAX_PRECISION) ? MAX_PRECISION : int'(prec_in);
        len = 0;
        skip = 0;
        if (size < 2) begin
            c = '{ch: CH_NUL, pos: 5'd0, last: 1'b1, len: 5'd0, no_store: 1'b1};
            expected_chars.push_back(c);
            return;
        end
        room = size - 1;
        pad = (int'(width_in) < room) ? int'(width_in) : room;
        if (bits[62:52] == EXP_SPECIAL) begin
            for (int i = 0; i < 3 && i < room; i++) begin
                if (bits[51:0] != 52'd0)
                    text[len] = (i == 1) ? "a" : "n";
                else
                    text[len] = (i == 0) ? "i" : ((i == 1) ? "n" : "f");
                len++;
            end
            skip = 1;
        end
        if (!skip) begin
            // Negative zero carries no sign.
            if (bits[63] && bits[62:0] != 63'd0) begin
                text[len] = CH_MINUS;
                len++;
                pad--;
                room--;
            end
            split_rounded(bits, p, ipart, fdig);
            nd = 1;
            for (t = ipart; t >= 64'd10; t = t / 10) nd++;
            if (nd <= room) begin
                t = ipart;
                for (int i = nd - 1; i >= 0; i--) begin
                    text[len + i] = CH_ZERO + 8'(t % 10);
                    t = t / 10;
                end
                len += nd;
                room -= nd;
                pad -= nd;
                if (p > 0 && room > 0) begin
                    text[len] = CH_DOT;
                    len++;
                    room--;
                    pad--;
                end
                for (int k = 0; k < p && room > 0; k++) begin
                    text[len] = CH_ZERO + 8'((fdig / ten_to(p - 1 - k)) % 10);
                    len++;
                    room--;
                    pad--;
                end
                if (pad > 0) begin
                    for (int i = len - 1; i >= 0; i--) text[i + pad] = text[i];
                    for (int i = 0; i < pad; i++) text[i] = CH_SPACE;
                    len += pad;
                end
            end
        end
        for (int i = 0; i < len; i++) begin
            c = '{ch: text[i], pos: 5'(i), last: 1'b0, len: 5'd0, no_store: 1'b0};
            expected_chars.push_back(c);
        end
        c = '{ch: CH_NUL, pos: 5'(len), last: 1'b1, len: 5'(len), no_store: 1'b0};
        expected_chars.push_back(c);
    endtask

    task automatic report_mismatch(input string what, input text_char_t want,
                                   input text_char_t seen);
        $display("[%0t] mismatch %s: want ch=%02h pos=%0d last=%0b len=%0d ns=%0b, %s",
                 $realtime, what, want.ch, want.pos, want.last, want.len, want.no_store,
                 $sformatf("got ch=%02h pos=%0d last=%0b len=%0d ns=%0b",
                           seen.ch, seen.pos, seen.last, seen.len, seen.no_store));
        fails++;
    endtask

    // Sample both channels at the rising edge, where the handshakes happen.
    always @(posedge clk) begin
        text_char_t want;
        text_char_t got;
        if (rst_n && in_valid && in_ready)
            predict_text(value_bits, buffer_size, field_width, precision);
        if (rst_n && out_valid && out_ready) begin
            got = '{ch: character, pos: position, last: last, len: length,
                    no_store: no_store};
            chars_seen++;
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected", '0, got);
            end
            else begin
                want = expected_chars.pop_front();
                if (got.ch != want.ch) report_mismatch("character", want, got);
                else if (got.pos != want.pos) report_mismatch("position", want, got);
                else if (got.last != want.last) report_mismatch("last", want, got);
                else if (got.len != want.len) report_mismatch("length", want, got);
                else if (got.no_store != want.no_store) report_mismatch("no_store", want, got);
            end
        end
        pending = expected_chars.size();
    end

endmodule

// File: verif/tb_fixed_width_decimal_formatter.sv
// Testbench top for the fixed-width decimal formatter: clock, reset, requests
// and receiver stalls; fwdf_checker does the prediction and comparison.
// Depends on fwdf_pkg, fixed_width_decimal_formatter and fwdf_checker.
`timescale 1ns / 1ps
module tb_fixed_width_decimal_formatter;
    import fwdf_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] value_bits;
    logic [5:0]  buffer_size;
    logic [4:0]  field_width;
    logic [3:0]  precision;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  character;
    logic [4:0]  position;
    logic        last;
    logic [4:0]  length;
    logic        no_store;

    int fails, pending, chars_seen;
    int requests_sent;
    int stall_left;
    bit char_taken;
    bit quiet;

    fixed_width_decimal_formatter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .value_bits(value_bits), .buffer_size(buffer_size),
        .field_width(field_width), .precision(precision),
        .out_valid(out_valid), .out_ready(out_ready),
        .character(character), .position(position), .last(last),
        .length(length), .no_store(no_store)
    );

    fwdf_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .value_bits(value_bits), .buffer_size(buffer_size),
        .field_width(field_width), .precision(precision),
        .out_valid(out_valid), .out_ready(out_ready),
        .character(character), .position(position), .last(last),
        .length(length), .no_store(no_store),
        .fails(fails), .pending(pending), .chars_seen(chars_seen)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: draw a stall before each character, none in quiet stretches.
    initial begin
        out_ready = 1'b0;
        stall_left = 0;
        char_taken = 1'b1;
    end

    always @(negedge clk) begin
        if (char_taken) stall_left = quiet ? 0 : $urandom_range(0, 5);
        else if (stall_left > 0) stall_left = stall_left - 1;
        out_ready <= (stall_left == 0);
        char_taken = rst_n && out_valid && (stall_left == 0);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [63:0] bits, input logic [5:0] size,
                                input logic [4:0] width, input logic [3:0] prec);
        int  gap;
        bit  rdy;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        value_bits <= bits;
        buffer_size <= size;
        field_width <= width;
        precision <= prec;
        do begin
            #0 rdy = in_ready;
            @(posedge clk);
            @(negedge clk);
        end while (!rdy);
        requests_sent++;
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1:    ;                                               // raw bits
            2:       v[62:52] = EXP_SPECIAL;                         // nan or inf
            3:       v[62:52] = 11'd0;                               // subnormal
            4:       v[62:52] = 11'($urandom_range(1050, 1060));     // near saturation
            default: v[62:52] = 11'($urandom_range(990, 1045));      // ordinary range
        endcase
        return v;
    endfunction

    initial begin
        logic [63:0] v;
        logic [5:0]  size;
        in_valid = 1'b0;
        value_bits = '0;
        buffer_size = '0;
        field_width = '0;
        precision = '0;
        requests_sent = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(64'h0000000000000000, 6'd32, 5'd0,  4'd3);
        send_request(64'h8000000000000000, 6'd32, 5'd8,  4'd2);    // negative zero
        send_request(64'h3FF8000000000000, 6'd32, 5'd0,  4'd0);    // 1.5 rounds up
        send_request(64'hC004000000000000, 6'd32, 5'd10, 4'd0);    // -2.5
        send_request(64'h3FC0000000000000, 6'd32, 5'd0,  4'd2);    // 0.125
        send_request(64'h3FEFFFFFFFFFFFFF, 6'd32, 5'd0,  4'd9);    // carry into integer
        send_request(64'h7FF8000000000001, 6'd32, 5'd20, 4'd1);    // nan, no padding
        send_request(64'h7FF0000000000000, 6'd3,  5'd0,  4'd1);    // inf cut short
        send_request(64'hFFF0000000000000, 6'd32, 5'd5,  4'd1);    // negative infinity
        send_request(64'hFFFFFFFFFFFFFFFF, 6'd2,  5'd31, 4'd15);
        send_request(64'h4415AF1D78B58C40, 6'd32, 5'd0,  4'd4);    // huge saturates
        send_request(64'h41EFFFFFFFF00000, 6'd32, 5'd0,  4'd0);    // saturates on rounding
        send_request(64'h41F0000000000000, 6'd40, 5'd31, 4'd9);
        send_request(64'h7FEFFFFFFFFFFFFF, 6'd63, 5'd0,  4'd15);
        send_request(64'h0000000000000001, 6'd32, 5'd0,  4'd9);    // smallest subnormal
        send_request(64'h8000000000000001, 6'd32, 5'd0,  4'd3);    // negative, rounds to 0
        send_request(64'h400921FB54442D18, 6'd0,  5'd0,  4'd4);    // nothing stored
        send_request(64'h400921FB54442D18, 6'd1,  5'd4,  4'd4);
        send_request(64'hC05EDD2F1A9FBE77, 6'd3,  5'd0,  4'd3);    // integer does not fit
        send_request(64'hC05EDD2F1A9FBE77, 6'd6,  5'd0,  4'd3);    // fraction cut
        send_request(64'hC05EDD2F1A9FBE77, 6'd32, 5'd31, 4'd3);
        send_request(64'h400921FB54442D18, 6'd12, 5'd15, 4'd8);

        for (int n = 0; n < 290; n++) begin
            if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
            v = pick_value();
            size = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(2, 32));
            send_request(v, size, 5'($urandom), 4'($urandom_range(0, 15)));
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);

        $display("Sent %0d requests (specials, saturation, rounding, cut buffers)", requests_sent);
        $display("Checked %0d characters, %0d mismatches", chars_seen, fails);
        if (fails == 0 && pending == 0) begin
            $display("SUCCESS");
        end
        else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: fixed_width_decimal_formatter.f
sv/fwdf_pkg.sv
sv/fwdf_front.sv
sv/fwdf_queue.sv
sv/fwdf_back.sv
sv/fixed_width_decimal_formatter.sv
verif/fwdf_checker.sv
verif/tb_fixed_width_decimal_formatter.sv
